/* rtl/core/usbm_pkg.sv */
// ----------------------------------------------------------------------------
// usbm_pkg: shared types and constants for the USB match table
// Record layout, cell control group, action and status codes.
// ----------------------------------------------------------------------------
package usbm_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
   localparam int MATCH_INDEX_W = 4;
   localparam int FLAGS_W       = 11;

   // action codes
   localparam logic [1:0] ACT_ADD    = 2'd0;
   localparam logic [1:0] ACT_DELETE = 2'd1;
   localparam logic [1:0] ACT_LOOKUP = 2'd2;

   // status codes
   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_NO_MATCH = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;

   // flag bit positions
   localparam int FLG_VENDOR  = 0;
   localparam int FLG_PRODUCT = 1;
   localparam int FLG_VER_LO  = 2;
   localparam int FLG_VER_HI  = 3;
   localparam int FLG_DCLASS  = 4;
   localparam int FLG_DSUB    = 5;
   localparam int FLG_DPROTO  = 6;
   localparam int FLG_ICLASS  = 7;
   localparam int FLG_ISUB    = 8;
   localparam int FLG_IPROTO  = 9;
   localparam int FLG_INUM    = 10;

   localparam logic [7:0] CLASS_VENDOR_SPEC = 8'hFF;

   typedef struct packed {
      logic [FLAGS_W-1:0] flags;
      logic [15:0]        vendor_id;
      logic [15:0]        product_id;
      logic [15:0]        version_low;
      logic [15:0]        version_high;
      logic [23:0]        device_class;
      logic [31:0]        interface_quad;
   } record_type;

   // device fields presented to every cell on a lookup or delete
   typedef struct packed {
      logic [15:0] vendor_id;
      logic [15:0] product_id;
      logic [15:0] version;
      logic [23:0] device_class;
      logic [31:0] interface_quad;
   } device_type;

   typedef struct packed {
      logic load;   // take the new record
      logic shift;  // take the right-hand neighbour's record
   } cell_ctrl_type;

   // lowest set position of a vector
   function automatic logic [IDX_W-1:0] first_set(input logic [TABLE_ENTRIES-1:0] vec);
      logic [IDX_W-1:0] pos;
      pos = '0;
      for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
         if (vec[k]) begin
            pos = IDX_W'(k);
         end
      end
      return pos;
   endfunction

endpackage

/* rtl/core/usb_device_id_match_table_top.sv */
// ----------------------------------------------------------------------------
// usb_device_id_match_table_top: ordered USB device match table
// Add, delete-by-id and first-match lookup over a row of record cells.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. req_action picks
//   add, delete (by vendor and product) or lookup; the other req_ ports carry
//   the record or the device description.
//   Each request gives exactly one response: rsp_valid is high for one cycle
//   with rsp_status and rsp_match_index.
//   The request is registered on the accepting edge; all cells compare it in
//   parallel while it is pending, and the outcome goes into the registered
//   response. busy is high for one cycle per request, and a new request can
//   be taken in the cycle the previous response is shown; the request
//   register in front of the cell row sets the pace, the registered response
//   adds to latency only.
//   A delete closes the gap by the hit cell and each later cell taking its
//   right-hand neighbour's record on the same edge; the last keeps its own.
//   Reset empties the table (count to zero) and clears busy and rsp_valid;
//   record contents are not cleared. The receiver cannot stall: the response
//   must be taken in its strobe cycle.
// ----------------------------------------------------------------------------
module usb_device_id_match_table_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [10:0] req_match_flags,
   input  logic [15:0] req_vendor_id,
   input  logic [15:0] req_product_id,
   input  logic [15:0] req_version_low,
   input  logic [15:0] req_version_high,
   input  logic [23:0] req_device_class_triple,
   input  logic [31:0] req_interface_quad,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_match_index
);
   import usbm_pkg::*;

   logic                         pend_ff, pend_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [1:0]                   rsp_status_ff, rsp_status_in;
   logic [MATCH_INDEX_W-1:0]     rsp_index_ff, rsp_index_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [1:0]                   action_ff;
   record_type                   new_rec_ff;
   device_type                   device;
   logic                         accept;

   record_type                   recs     [TABLE_ENTRIES];
   cell_ctrl_type                ctrl     [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0]     match_raw, hit_raw, occupied;
   logic [TABLE_ENTRIES-1:0]     match_vec, hit_vec;
   logic [IDX_W-1:0]             match_pos, hit_pos, add_pos;
   logic                         table_full;
   logic                         do_add, do_delete;

   assign accept = start && !busy;
   assign busy   = pend_ff;

   // request register
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff                 <= req_action;
         new_rec_ff.flags          <= req_match_flags;
         new_rec_ff.vendor_id      <= req_vendor_id;
         new_rec_ff.product_id     <= req_product_id;
         new_rec_ff.version_low    <= req_version_low;
         new_rec_ff.version_high   <= req_version_high;
         new_rec_ff.device_class   <= req_device_class_triple;
         new_rec_ff.interface_quad <= req_interface_quad;
      end
   end

   assign device.vendor_id      = new_rec_ff.vendor_id;
   assign device.product_id     = new_rec_ff.product_id;
   assign device.version        = new_rec_ff.version_low;
   assign device.device_class   = new_rec_ff.device_class;
   assign device.interface_quad = new_rec_ff.interface_quad;

   // cell row
   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      record_type next_rec;
      if (i == TABLE_ENTRIES - 1) begin : g_last
         assign next_rec = recs[i];
      end else begin : g_mid
         assign next_rec = recs[i+1];
      end

      assign occupied[i] = CNT_W'(i) < count_ff;

      assign ctrl[i].load  = do_add && (add_pos == IDX_W'(i));
      assign ctrl[i].shift = do_delete && (hit_pos <= IDX_W'(i));

      usbm_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl[i]),
         .new_rec  (new_rec_ff),
         .next_rec (next_rec),
         .device   (device),
         .rec      (recs[i]),
         .match    (match_raw[i]),
         .id_hit   (hit_raw[i])
      );
   end

   assign match_vec  = match_raw & occupied;
   assign hit_vec    = hit_raw & occupied;
   assign match_pos  = first_set(match_vec);
   assign hit_pos    = first_set(hit_vec);
   assign table_full = count_ff >= CNT_W'(TABLE_ENTRIES);
   assign add_pos    = count_ff[IDX_W-1:0];
   assign do_add     = pend_ff && (action_ff == ACT_ADD) && !table_full;
   assign do_delete  = pend_ff && (action_ff == ACT_DELETE) && (|hit_vec);

   // execute and build the response
   always_comb begin
      pend_in       = pend_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      count_in      = count_ff;
      if (accept) begin
         pend_in = 1'b1;
      end else if (pend_ff) begin
         pend_in       = 1'b0;
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_NO_MATCH;
         rsp_index_in  = '0;
         unique case (action_ff)
            ACT_ADD: begin
               if (table_full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  rsp_status_in = ST_DONE;
                  rsp_index_in  = MATCH_INDEX_W'(add_pos);
                  count_in      = count_ff + CNT_W'(1);
               end
            end
            ACT_DELETE: begin
               rsp_status_in = ST_DONE;
               if (|hit_vec) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
            ACT_LOOKUP: begin
               if (|match_vec) begin
                  rsp_status_in = ST_DONE;
                  rsp_index_in  = MATCH_INDEX_W'(match_pos);
               end
            end
            default: begin
               rsp_status_in = ST_NO_MATCH;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_match_index = rsp_index_ff;

endmodule

/* rtl/core/usbm_cell.sv */
// ----------------------------------------------------------------------------
// usbm_cell: one table slot
// Holds a record, compares it against the device, loads or takes its
// neighbour's record when the table closes a gap.
// ----------------------------------------------------------------------------
module usbm_cell (
   input  logic                    clock,
   input  usbm_pkg::cell_ctrl_type ctrl,
   input  usbm_pkg::record_type    new_rec,
   input  usbm_pkg::record_type    next_rec,
   input  usbm_pkg::device_type    device,
   output usbm_pkg::record_type    rec,
   output logic                    match,
   output logic                    id_hit
);
   import usbm_pkg::*;

   record_type rec_ff;
   record_type rec_in;
   logic       vendor_spec_reject;

   // slot storage
   always_comb begin
      rec_in = rec_ff;
      if (ctrl.load) begin
         rec_in = new_rec;
      end else if (ctrl.shift) begin
         rec_in = next_rec;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec = rec_ff;

   // delete key: vendor and product both equal
   assign id_hit = (rec_ff.vendor_id == device.vendor_id) &&
                   (rec_ff.product_id == device.product_id);

   // vendor-specific class refuses interface-only records
   assign vendor_spec_reject = (device.device_class[23:16] == CLASS_VENDOR_SPEC) &&
                               !rec_ff.flags[FLG_VENDOR] &&
                               (rec_ff.flags[FLG_ICLASS] || rec_ff.flags[FLG_ISUB] ||
                                rec_ff.flags[FLG_IPROTO] || rec_ff.flags[FLG_INUM]);

   // field compare, each gated by its flag
   always_comb begin
      match = !vendor_spec_reject;
      if (rec_ff.flags[FLG_VENDOR] && rec_ff.vendor_id != device.vendor_id) match = 1'b0;
      if (rec_ff.flags[FLG_PRODUCT] && rec_ff.product_id != device.product_id) match = 1'b0;
      if (rec_ff.flags[FLG_VER_LO] && rec_ff.version_low > device.version) match = 1'b0;
      if (rec_ff.flags[FLG_VER_HI] && rec_ff.version_high < device.version) match = 1'b0;
      if (rec_ff.flags[FLG_DCLASS] &&
          rec_ff.device_class[23:16] != device.device_class[23:16]) match = 1'b0;
      if (rec_ff.flags[FLG_DSUB] &&
          rec_ff.device_class[15:8] != device.device_class[15:8]) match = 1'b0;
      if (rec_ff.flags[FLG_DPROTO] &&
          rec_ff.device_class[7:0] != device.device_class[7:0]) match = 1'b0;
      if (rec_ff.flags[FLG_ICLASS] &&
          rec_ff.interface_quad[31:24] != device.interface_quad[31:24]) match = 1'b0;
      if (rec_ff.flags[FLG_ISUB] &&
          rec_ff.interface_quad[23:16] != device.interface_quad[23:16]) match = 1'b0;
      if (rec_ff.flags[FLG_IPROTO] &&
          rec_ff.interface_quad[15:8] != device.interface_quad[15:8]) match = 1'b0;
      if (rec_ff.flags[FLG_INUM] &&
          rec_ff.interface_quad[7:0] != device.interface_quad[7:0]) match = 1'b0;
   end

endmodule
